// File: hw/rtl/dfalex_pkg.sv
// Shared types and constants for the table-driven DFA lexer.
// Used by the step logic, the result queue and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package dfalex_pkg;

    // Default sizes for the top-level parameters
    localparam int NUM_STATES_DEF    = 64;
    localparam int NUM_TOKEN_IDS_DEF = 256;

    // Field widths
    localparam int POS_W   = 16;
    localparam int STATE_W = 6;
    localparam int CHAR_W  = 8;
    localparam int ID_W    = 8;
    localparam int ENTRY_W = STATE_W + 1;          // valid bit over target state
    localparam int INFO_W  = 1 + 2 + ID_W;          // accept, class, token id

    // Input item kinds
    typedef enum logic [1:0] {
        KIND_CHAR       = 2'd0,
        KIND_EOF        = 2'd1,
        KIND_LOAD_TRANS = 2'd2,
        KIND_LOAD_INFO  = 2'd3
    } in_kind_t;

    // Result kinds
    typedef enum logic [1:0] {
        RES_TOKEN       = 2'd0,
        RES_EOF         = 2'd1,
        RES_ERR_STUCK   = 2'd2,
        RES_ERR_NONTERM = 2'd3
    } res_kind_t;

    // State attribute classes
    localparam logic [1:0] CLS_TERMINAL = 2'd0;
    localparam logic [1:0] CLS_SPACE    = 2'd1;

    // Lexer state carried from byte to byte
    typedef struct packed {
        logic [STATE_W-1:0] cur_state;
        logic [POS_W-1:0]   byte_pos;
        logic [POS_W-1:0]   tok_start;
        logic [POS_W-1:0]   tok_len;
        logic               halted;
    } lex_state_t;

    // One result item
    typedef struct packed {
        res_kind_t          kind;
        logic [ID_W-1:0]    token;
        logic [POS_W-1:0]   start;
        logic [POS_W-1:0]   length;
        logic [STATE_W-1:0] err_state;
        logic               last;
    } result_t;

endpackage

`default_nettype wire

// File: hw/rtl/dfalex_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dfalex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: hw/rtl/dfalex_step.sv
// Next-state and result logic for one character or end-of-input item.
// Depends on dfalex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfalex_step #(
    parameter int NUM_STATES    = dfalex_pkg::NUM_STATES_DEF,
    parameter int NUM_TOKEN_IDS = dfalex_pkg::NUM_TOKEN_IDS_DEF
) (
    input  wire logic                                is_eof,
    input  wire dfalex_pkg::lex_state_t              st_cur,
    input  wire logic [dfalex_pkg::STATE_W-1:0]      start_state,
    input  wire logic [dfalex_pkg::ENTRY_W-1:0]      cur_entry,
    input  wire logic [dfalex_pkg::ENTRY_W-1:0]      start_entry,
    input  wire logic [dfalex_pkg::INFO_W-1:0]       info,
    output dfalex_pkg::lex_state_t                   st_next,
    output dfalex_pkg::result_t                      res0,
    output dfalex_pkg::result_t                      res1,
    output logic [1:0]                               res_cnt
);

    import dfalex_pkg::*;

    logic               cur_ok;
    logic               start_ok;
    logic               mv_cur;
    logic               mv_start;
    logic               acc;
    logic [1:0]         cls;
    logic [ID_W-1:0]    id;
    logic               id_ok;
    result_t            fl_res;
    logic               fl_vld;
    logic               fl_halt;
    result_t            fr;
    logic               fr_vld;
    result_t            sr;
    logic               sr_vld;
    logic [POS_W-1:0]   len_inc;

    // Range checks on states and lookups
    assign cur_ok   = 32'(st_cur.cur_state) < NUM_STATES;
    assign start_ok = 32'(start_state) < NUM_STATES;
    assign mv_cur   = cur_ok && cur_entry[STATE_W]
                      && (32'(cur_entry[STATE_W-1:0]) < NUM_STATES);
    assign mv_start = start_ok && start_entry[STATE_W]
                      && (32'(start_entry[STATE_W-1:0]) < NUM_STATES);

    // Attributes of the current state; out-of-range states never accept
    assign acc   = cur_ok && info[INFO_W-1];
    assign cls   = info[ID_W+1:ID_W];
    assign id    = info[ID_W-1:0];
    assign id_ok = 32'(id) < NUM_TOKEN_IDS;

    // Saturating length increment
    assign len_inc = (st_cur.tok_len == '1) ? st_cur.tok_len : st_cur.tok_len + POS_W'(1);

    // Outcome of closing the pending token
    always_comb begin
        fl_res           = '0;
        fl_res.start     = st_cur.tok_start;
        fl_res.length    = st_cur.tok_len;
        fl_vld           = 1'b0;
        fl_halt          = 1'b0;
        if (!acc) begin
            fl_res.kind      = RES_ERR_STUCK;
            fl_res.err_state = st_cur.cur_state;
            fl_vld           = 1'b1;
            fl_halt          = 1'b1;
        end else if (cls == CLS_TERMINAL && id_ok) begin
            fl_res.kind  = RES_TOKEN;
            fl_res.token = id;
            fl_vld       = 1'b1;
        end else if (cls == CLS_SPACE) begin
            fl_vld = 1'b0;
        end else begin
            fl_res.kind      = RES_ERR_NONTERM;
            fl_res.err_state = st_cur.cur_state;
            fl_vld           = 1'b1;
            fl_halt          = 1'b1;
        end
    end

    // Main step: move, close token and retry from start, or end of input
    always_comb begin
        st_next = st_cur;
        fr      = fl_res;
        fr_vld  = 1'b0;
        sr      = '0;
        sr_vld  = 1'b0;
        if (is_eof) begin
            fr_vld   = !st_cur.halted && (st_cur.tok_len != '0) && fl_vld;
            sr.kind  = RES_EOF;
            sr.start = st_cur.byte_pos;
            sr_vld   = 1'b1;
            st_next.cur_state = start_state;
            st_next.byte_pos  = '0;
            st_next.tok_start = '0;
            st_next.tok_len   = '0;
            st_next.halted    = 1'b0;
        end else if (!st_cur.halted) begin
            if (mv_cur) begin
                if (st_cur.tok_len == '0) begin
                    st_next.tok_start = st_cur.byte_pos;
                end
                st_next.cur_state = cur_entry[STATE_W-1:0];
                st_next.tok_len   = len_inc;
                st_next.byte_pos  = st_cur.byte_pos + POS_W'(1);
            end else begin
                fr_vld = fl_vld;
                if (fl_halt) begin
                    st_next.halted = 1'b1;
                end else if (mv_start) begin
                    // retried byte starts a fresh token
                    st_next.cur_state = start_entry[STATE_W-1:0];
                    st_next.tok_start = st_cur.byte_pos;
                    st_next.tok_len   = POS_W'(1);
                    st_next.byte_pos  = st_cur.byte_pos + POS_W'(1);
                end else begin
                    sr.kind           = RES_ERR_STUCK;
                    sr.start          = st_cur.byte_pos;
                    sr.err_state      = start_state;
                    sr_vld            = 1'b1;
                    st_next.cur_state = start_state;
                    st_next.tok_start = st_cur.byte_pos;
                    st_next.tok_len   = '0;
                    st_next.halted    = 1'b1;
                end
            end
        end
    end

    // Pack results in order, marking the final one
    always_comb begin
        res0      = fr_vld ? fr : sr;
        res0.last = !(fr_vld && sr_vld);
        res1      = sr;
        res1.last = 1'b1;
        res_cnt   = {1'b0, fr_vld} + {1'b0, sr_vld};
    end

endmodule

`default_nettype wire

// File: hw/rtl/dfalex_outq.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
// Depends on dfalex_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfalex_outq (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic [1:0]            push_cnt,
    input  wire dfalex_pkg::result_t   push0,
    input  wire dfalex_pkg::result_t   push1,
    output logic                       has_room,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output dfalex_pkg::result_t        out_res
);

    import dfalex_pkg::*;

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;

    result_t         mem_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   wr_ptr_next;
    logic [AW-1:0]   wr_ptr1;
    logic [AW-1:0]   rd_ptr_reg;
    logic [AW-1:0]   rd_ptr_next;
    logic [CW-1:0]   cnt_reg;
    logic [CW-1:0]   cnt_next;
    logic            pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = cnt_reg != '0;
    assign out_res   = mem_reg[rd_ptr_reg];
    assign has_room  = cnt_reg <= CW'(DEPTH - 2);
    assign wr_ptr1   = wr_ptr_reg + AW'(1);

    // Pointer and fill-level updates
    always_comb begin
        wr_ptr_next = wr_ptr_reg + AW'(push_cnt);
        rd_ptr_next = rd_ptr_reg + AW'(pop);
        cnt_next    = cnt_reg + CW'(push_cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr1] <= push1;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/dfa_maximal_munch_lexer.sv
// Top level of the table-driven DFA lexer: register port, tables, step stage.
// Depends on dfalex_pkg, dfalex_ram, dfalex_step and dfalex_outq.
//
// Takes one item per clock. A character or end-of-input item reads the transition table
// (from the current state and from the start state) and the state attribute table in
// the cycle it is accepted; the step stage then resolves the move, token boundary and retry
// and writes zero, one or two results into a four-entry result queue, where they are
// registered before they are visible. The input stalls only while that queue holds more
// than two results. Table loads give no result. The transition table is kept in two
// identical copies, one per lookup. The tables are not cleared by reset and must be
// loaded before use; there is no start-up sweep.
`timescale 1ns / 1ps
`default_nettype none

module dfa_maximal_munch_lexer #(
    parameter int NUM_STATES    = dfalex_pkg::NUM_STATES_DEF,
    parameter int NUM_TOKEN_IDS = dfalex_pkg::NUM_TOKEN_IDS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // register port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    // input items
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic [1:0]                        s_kind,
    input  wire logic [dfalex_pkg::CHAR_W-1:0]     s_char_code,
    input  wire logic [dfalex_pkg::STATE_W-1:0]    s_state_index,
    input  wire logic [dfalex_pkg::STATE_W-1:0]    s_target_state,
    input  wire logic                              s_target_valid,
    input  wire logic                              s_accepting,
    input  wire logic [1:0]                        s_token_class,
    input  wire logic [dfalex_pkg::ID_W-1:0]       s_token_id,
    // results
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [1:0]                             m_result_kind,
    output logic [dfalex_pkg::ID_W-1:0]            m_result_token,
    output logic [dfalex_pkg::POS_W-1:0]           m_token_start,
    output logic [dfalex_pkg::POS_W-1:0]           m_token_length,
    output logic [dfalex_pkg::STATE_W-1:0]         m_error_state,
    output logic                                   m_last
);

    import dfalex_pkg::*;

    localparam int SIDX_W   = $clog2(NUM_STATES);
    localparam int TR_DEPTH = NUM_STATES * 256;
    localparam int TR_AW    = $clog2(TR_DEPTH);

    localparam logic REG_CASE  = 1'b0;
    localparam logic REG_START = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    in_kind_t               in_kind;
    logic                   accept;
    logic                   is_lex_item;
    logic                   si_ok;
    logic                   fire;
    logic                   q_room;
    logic                   cfg_wr;
    logic [CHAR_W-1:0]      char_fold;

    logic                   case_sens_reg;
    logic [STATE_W-1:0]     start_state_reg;
    logic                   stg_vld_reg;
    logic                   stg_vld_next;
    logic                   stg_eof_reg;
    lex_state_t             state_reg;
    lex_state_t             state_next;
    lex_state_t             step_state;

    logic [SIDX_W+STATE_W-1:0] si_ext;
    logic [SIDX_W+STATE_W-1:0] cur_ext;
    logic [SIDX_W+STATE_W-1:0] start_ext;
    logic [SIDX_W-1:0]         si_addr;
    logic [SIDX_W-1:0]         cur_addr;
    logic [SIDX_W-1:0]         start_addr;

    logic [ENTRY_W-1:0]     cur_entry;
    logic [ENTRY_W-1:0]     start_entry;
    logic [INFO_W-1:0]      info;
    logic                   tr_we;
    logic                   info_we;
    logic                   rd_en;

    result_t                res0;
    result_t                res1;
    result_t                out_res;
    logic [1:0]             res_cnt;
    logic [1:0]             push_cnt;

    // Register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        case (paddr[2])
            REG_CASE:  prdata = {31'd0, case_sens_reg};
            REG_START: prdata = {{(32 - STATE_W){1'b0}}, start_state_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            case_sens_reg   <= 1'b0;
            start_state_reg <= '0;
        end else if (cfg_wr) begin
            if (paddr[2] == REG_CASE) begin
                case_sens_reg <= pwdata[0];
            end else begin
                start_state_reg <= pwdata[STATE_W-1:0];
            end
        end
    end

    // Input handshake; stage advances when the queue can take two results
    assign in_kind     = in_kind_t'(s_kind);
    assign fire        = stg_vld_reg && q_room;
    assign s_ready     = !stg_vld_reg || fire;
    assign accept      = s_valid && s_ready;
    assign is_lex_item = (in_kind == KIND_CHAR) || (in_kind == KIND_EOF);
    assign si_ok       = 32'(s_state_index) < NUM_STATES;

    // Case folding of A-Z
    assign char_fold = (!case_sens_reg && s_char_code >= CHAR_UPPER_A
                        && s_char_code <= CHAR_UPPER_Z) ? s_char_code + CASE_OFFSET
                                                        : s_char_code;

    // Lexer state seen by the item being accepted
    always_comb begin
        state_next = fire ? step_state : state_reg;
        if (cfg_wr && paddr[2] == REG_START && state_reg.tok_len == '0) begin
            state_next.cur_state = pwdata[STATE_W-1:0];
        end
    end

    // State indexes trimmed to the table address width
    assign si_ext     = {{SIDX_W{1'b0}}, s_state_index};
    assign cur_ext    = {{SIDX_W{1'b0}}, state_next.cur_state};
    assign start_ext  = {{SIDX_W{1'b0}}, start_state_reg};
    assign si_addr    = si_ext[SIDX_W-1:0];
    assign cur_addr   = cur_ext[SIDX_W-1:0];
    assign start_addr = start_ext[SIDX_W-1:0];

    assign tr_we   = accept && (in_kind == KIND_LOAD_TRANS) && si_ok;
    assign info_we = accept && (in_kind == KIND_LOAD_INFO) && si_ok;
    assign rd_en   = accept && is_lex_item;

    // Transition table, lookup from the current state
    dfalex_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TR_DEPTH)
    ) u_tr_cur (
        .aclk  (aclk),
        .we    (tr_we),
        .waddr (TR_AW'({si_addr, s_char_code})),
        .wdata ({s_target_valid, s_target_state}),
        .re    (rd_en),
        .raddr (TR_AW'({cur_addr, char_fold})),
        .rdata (cur_entry)
    );

    // Second copy of the transition table, lookup from the start state
    dfalex_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TR_DEPTH)
    ) u_tr_start (
        .aclk  (aclk),
        .we    (tr_we),
        .waddr (TR_AW'({si_addr, s_char_code})),
        .wdata ({s_target_valid, s_target_state}),
        .re    (rd_en),
        .raddr (TR_AW'({start_addr, char_fold})),
        .rdata (start_entry)
    );

    // State attribute table
    dfalex_ram #(
        .WIDTH (INFO_W),
        .DEPTH (NUM_STATES)
    ) u_info (
        .aclk  (aclk),
        .we    (info_we),
        .waddr (si_addr),
        .wdata ({s_accepting, s_token_class, s_token_id}),
        .re    (rd_en),
        .raddr (cur_addr),
        .rdata (info)
    );

    // Stage control and lexer state
    always_comb begin
        if (accept) begin
            stg_vld_next = is_lex_item;
        end else if (fire) begin
            stg_vld_next = 1'b0;
        end else begin
            stg_vld_next = stg_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stg_vld_reg <= 1'b0;
            state_reg   <= '0;
        end else begin
            stg_vld_reg <= stg_vld_next;
            state_reg   <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_eof_reg <= (in_kind == KIND_EOF);
        end
    end

    // Step logic
    dfalex_step #(
        .NUM_STATES    (NUM_STATES),
        .NUM_TOKEN_IDS (NUM_TOKEN_IDS)
    ) u_step (
        .is_eof      (stg_eof_reg),
        .st_cur      (state_reg),
        .start_state (start_state_reg),
        .cur_entry   (cur_entry),
        .start_entry (start_entry),
        .info        (info),
        .st_next     (step_state),
        .res0        (res0),
        .res1        (res1),
        .res_cnt     (res_cnt)
    );

    assign push_cnt = fire ? res_cnt : 2'd0;

    // Result queue
    dfalex_outq u_outq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .has_room  (q_room),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_res   (out_res)
    );

    assign m_result_kind  = out_res.kind;
    assign m_result_token = out_res.token;
    assign m_token_start  = out_res.start;
    assign m_token_length = out_res.length;
    assign m_error_state  = out_res.err_state;
    assign m_last         = out_res.last;

endmodule

`default_nettype wire
